/* rtl/tgarle_pkg.sv */
`default_nettype none

package tgarle_pkg;

  localparam int unsigned MAX_COLUMNS = 4096;
  localparam int unsigned MAX_ROWS    = 4096;

  localparam int unsigned DIM_W     = 13;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned IDX_W     = 24;
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP      = 2'd3;

  localparam logic [7:0] HDR_REPEAT_MIN = 8'd128;
  localparam logic [7:0] REPEAT_BIAS    = 8'd127;

  typedef struct packed {
    logic clear;
    logic check;
    logic commit;
  } place_ctrl_t;

  typedef struct packed {
    logic blocked;
    logic done;
  } place_stat_t;

endpackage

`default_nettype wire

/* rtl/tgarle_place.sv */
`default_nettype none

module tgarle_place import tgarle_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DIM_W-1:0] columns_i,
  input  logic [DIM_W-1:0] rows_i,
  input  logic             flip_i,
  input  place_ctrl_t      ctrl_i,
  output place_stat_t      stat_o,
  output logic [IDX_W-1:0] index_o
);

  logic [DIM_W-1:0]       cols;
  logic [DIM_W-1:0]       rows;
  logic [POS_W-1:0]       col_q;
  logic [POS_W-1:0]       row_q;
  logic                   fin_q;
  logic [POS_W+DIM_W-1:0] prod_q;
  logic [POS_W+DIM_W-1:0] prod_d;
  logic [DIM_W-1:0]       dest_row;
  logic [DIM_W-1:0]       col_inc;
  logic [DIM_W-1:0]       row_inc;
  logic                   out_of_range;
  logic                   wrap;
  logic                   done;

  always_comb begin
    cols = columns_i;
    if (cols == '0) begin
      cols = DIM_W'(1);
    end else if (cols > DIM_W'(MAX_COLUMNS)) begin
      cols = DIM_W'(MAX_COLUMNS);
    end
    rows = rows_i;
    if (rows == '0) begin
      rows = DIM_W'(1);
    end else if (rows > DIM_W'(MAX_ROWS)) begin
      rows = DIM_W'(MAX_ROWS);
    end
  end

  assign out_of_range = ({1'b0, col_q} >= cols) || ({1'b0, row_q} >= rows);

  // The row is in range whenever the product is used, so it fits POS_W bits.
  assign dest_row = flip_i ? (rows - DIM_W'(1) - {1'b0, row_q}) : {1'b0, row_q};
  assign prod_d   = (POS_W+DIM_W)'(dest_row[POS_W-1:0]) * (POS_W+DIM_W)'(cols);

  assign col_inc = {1'b0, col_q} + DIM_W'(1);
  assign row_inc = {1'b0, row_q} + DIM_W'(1);
  assign wrap    = col_inc >= cols;
  assign done    = wrap && (row_inc >= rows);

  assign index_o        = prod_q[IDX_W-1:0] + IDX_W'(col_q);
  assign stat_o.blocked = fin_q || out_of_range;
  assign stat_o.done    = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      fin_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      col_q <= '0;
      row_q <= '0;
      fin_q <= 1'b0;
    end else if (ctrl_i.check) begin
      if (out_of_range) begin
        fin_q <= 1'b1;
      end
    end else if (ctrl_i.commit) begin
      if (wrap) begin
        col_q <= '0;
        row_q <= row_inc[POS_W-1:0];
      end else begin
        col_q <= col_inc[POS_W-1:0];
      end
      if (done) begin
        fin_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.check) begin
      prod_q <= prod_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/tga_rle_pixel_decoder.sv */
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    data_byte_i, image_start_i
// out       out_valid_o / out_ready_i  first/second pixel and index, flags
// cfg       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A header byte or a non-final pixel byte leaves the sequencer idle, so the input stays ready.
// A completed pixel holds the input while each placed pixel passes the multiply
// state and then the add state, and each result word passes the emit state; one
// shared multiply-add places the pixels of a repeat packet one after another.
// Reset clears all counters and sets the registers to one column, one row.
// A stalled output holds the sequencer only when a second word is ready.
`default_nettype none

module tga_rle_pixel_decoder import tgarle_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 image_start_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIX_W-1:0]     first_pixel_o,
  output logic [IDX_W-1:0]     first_index_o,
  output logic [PIX_W-1:0]     second_pixel_o,
  output logic [IDX_W-1:0]     second_index_o,
  output logic                 second_valid_o,
  output logic                 run_last_o,
  output logic                 image_done_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [DIM_W-1:0] columns_q;
  logic [DIM_W-1:0] rows_q;
  logic             four_q;
  logic             flip_q;

  logic [1:0]       state_q;
  logic             exp_hdr_q;
  logic             rep_q;
  logic [7:0]       remain_q;
  logic [1:0]       bpos_q;
  logic [PIX_W-1:0] gather_q;
  logic [7:0]       cnt_q;
  logic             slot_q;
  logic             last_q;
  logic             out_valid_q;

  logic [PIX_W-1:0] pix_q;
  logic [PIX_W-1:0] p_first_pix_q;
  logic [IDX_W-1:0] p_first_idx_q;
  logic [PIX_W-1:0] p_second_pix_q;
  logic [IDX_W-1:0] p_second_idx_q;
  logic             p_sv_q;
  logic             p_done_q;
  logic [PIX_W-1:0] o_first_pix_q;
  logic [IDX_W-1:0] o_first_idx_q;
  logic [PIX_W-1:0] o_second_pix_q;
  logic [IDX_W-1:0] o_second_idx_q;
  logic             o_sv_q;
  logic             o_last_q;
  logic             o_done_q;

  logic             in_acc;
  logic             exp_b;
  logic             rep_b;
  logic [7:0]       remain_b;
  logic [1:0]       bpos_b;
  logic [PIX_W-1:0] gather_b;
  logic [PIX_W-1:0] gather_new;
  logic [1:0]       last_pos;
  logic [7:0]       remain_dec;
  logic [PIX_W-1:0] rgba;
  logic             pair_last;
  logic             emit_load;

  place_ctrl_t      pctrl;
  place_stat_t      pstat;
  logic [IDX_W-1:0] pindex;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= DIM_W'(1);
      rows_q    <= DIM_W'(1);
      four_q    <= 1'b0;
      flip_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_COLUMNS:   columns_q <= cfg_data_i;
        CFG_ROWS:      rows_q    <= cfg_data_i;
        CFG_FOUR_BYTE: four_q    <= cfg_data_i[0];
        CFG_FLIP:      flip_q    <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // A start flag clears the packet state before this byte is decoded.
  assign exp_b    = image_start_i ? 1'b1 : exp_hdr_q;
  assign rep_b    = image_start_i ? 1'b0 : rep_q;
  assign remain_b = image_start_i ? '0 : remain_q;
  assign bpos_b   = image_start_i ? '0 : bpos_q;
  assign gather_b = image_start_i ? '0 : gather_q;

  assign gather_new = gather_b | (PIX_W'(data_byte_i) << {bpos_b, 3'b000});
  assign last_pos   = four_q ? 2'd3 : 2'd2;
  assign remain_dec = (remain_b != '0) ? (remain_b - 8'd1) : '0;
  assign rgba       = {gather_new[23:16], gather_new[15:8], gather_new[7:0],
                       four_q ? gather_new[31:24] : 8'h00};
  assign pair_last  = (cnt_q == 8'd1) || pstat.done;
  assign emit_load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  assign pctrl.clear  = in_acc && image_start_i;
  assign pctrl.check  = (state_q == ST_MUL);
  assign pctrl.commit = (state_q == ST_ADD);

  tgarle_place u_place (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .columns_i (columns_q),
    .rows_i    (rows_q),
    .flip_i    (flip_q),
    .ctrl_i    (pctrl),
    .stat_o    (pstat),
    .index_o   (pindex)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      exp_hdr_q   <= 1'b1;
      rep_q       <= 1'b0;
      remain_q    <= '0;
      bpos_q      <= '0;
      gather_q    <= '0;
      cnt_q       <= '0;
      slot_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (exp_b) begin
              exp_hdr_q <= 1'b0;
              bpos_q    <= '0;
              gather_q  <= '0;
              if (data_byte_i < HDR_REPEAT_MIN) begin
                rep_q    <= 1'b0;
                remain_q <= data_byte_i + 8'd1;
              end else begin
                rep_q    <= 1'b1;
                remain_q <= data_byte_i - REPEAT_BIAS;
              end
            end else if (bpos_b < last_pos) begin
              exp_hdr_q <= exp_b;
              rep_q     <= rep_b;
              remain_q  <= remain_b;
              bpos_q    <= bpos_b + 2'd1;
              gather_q  <= gather_new;
            end else begin
              rep_q    <= rep_b;
              bpos_q   <= '0;
              gather_q <= '0;
              slot_q   <= 1'b0;
              state_q  <= ST_MUL;
              if (!rep_b) begin
                remain_q  <= remain_dec;
                exp_hdr_q <= (remain_dec == '0);
                cnt_q     <= 8'd1;
              end else begin
                remain_q  <= '0;
                exp_hdr_q <= 1'b1;
                cnt_q     <= remain_b;
              end
            end
          end
        end
        ST_MUL: begin
          if (pstat.blocked) begin
            // A dropped pixel ends the run; a half-filled word still goes out.
            if (slot_q) begin
              last_q  <= 1'b1;
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_IDLE;
            end
          end else begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          cnt_q <= cnt_q - 8'd1;
          if (!slot_q && !pair_last) begin
            slot_q  <= 1'b1;
            state_q <= ST_MUL;
          end else begin
            last_q  <= pair_last;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            slot_q  <= 1'b0;
            state_q <= last_q ? ST_IDLE : ST_MUL;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !exp_b && !(bpos_b < last_pos)) begin
      pix_q <= rgba;
    end
    if (state_q == ST_ADD) begin
      p_done_q <= pstat.done;
      if (!slot_q) begin
        p_first_pix_q  <= pix_q;
        p_first_idx_q  <= pindex;
        p_second_pix_q <= '0;
        p_second_idx_q <= '0;
        p_sv_q         <= 1'b0;
      end else begin
        p_second_pix_q <= pix_q;
        p_second_idx_q <= pindex;
        p_sv_q         <= 1'b1;
      end
    end
    if (emit_load) begin
      o_first_pix_q  <= p_first_pix_q;
      o_first_idx_q  <= p_first_idx_q;
      o_second_pix_q <= p_second_pix_q;
      o_second_idx_q <= p_second_idx_q;
      o_sv_q         <= p_sv_q;
      o_last_q       <= last_q;
      o_done_q       <= p_done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign first_pixel_o  = o_first_pix_q;
  assign first_index_o  = o_first_idx_q;
  assign second_pixel_o = o_second_pix_q;
  assign second_index_o = o_second_idx_q;
  assign second_valid_o = o_sv_q;
  assign run_last_o     = o_last_q;
  assign image_done_o   = o_done_q;

`ifndef NO_ASSERTIONS
  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && image_done_o |-> run_last_o)
    else $error("image_done without run_last");

  a_single_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !second_valid_o |-> (second_pixel_o == '0) && (second_index_o == '0))
    else $error("second pixel not cleared in a single-pixel word");

  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) || (state_q == ST_ADD) |-> (cnt_q != '0))
    else $error("pixel count exhausted while placing");

  a_half_word_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !slot_q)
    else $error("half-filled word left behind");
`endif

endmodule

`default_nettype wire

/* verif/tga_rle_pixel_check.sv */
module tga_rle_pixel_check import tgarle_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 image_start_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [PIX_W-1:0]     first_pixel_i,
  input  logic [IDX_W-1:0]     first_index_i,
  input  logic [PIX_W-1:0]     second_pixel_i,
  input  logic [IDX_W-1:0]     second_index_i,
  input  logic                 second_valid_i,
  input  logic                 run_last_i,
  input  logic                 image_done_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  output int                   pending_o,
  output int                   mismatch_o,
  output int                   checked_o
);

  typedef struct packed {
    logic [PIX_W-1:0] first_pixel;
    logic [IDX_W-1:0] first_index;
    logic [PIX_W-1:0] second_pixel;
    logic [IDX_W-1:0] second_index;
    logic             second_valid;
    logic             run_last;
    logic             image_done;
  } pixel_pair_t;

  pixel_pair_t pairs_due[$];
  int          mismatches;
  int          words_checked;

  // Register copies.
  logic [DIM_W-1:0] columns_q;
  logic [DIM_W-1:0] rows_q;
  logic             four_byte_q;
  logic             flip_q;

  // Decoder state.
  logic             header_next;
  logic             in_repeat;
  logic [7:0]       pixels_left;
  logic [1:0]       byte_pos;
  logic [31:0]      gather;
  logic [IDX_W-1:0] placed_total;
  int unsigned      column;
  int unsigned      row;
  logic             image_full;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned top_v);
    if (v == '0) return 1;
    if (v > top_v) return top_v;
    return int'(v);
  endfunction

  task automatic clear_counters();
    header_next  = 1'b1;
    in_repeat    = 1'b0;
    pixels_left  = '0;
    byte_pos     = '0;
    gather       = '0;
    placed_total = '0;
    column       = 0;
    row          = 0;
    image_full   = 1'b0;
  endtask

  // Places one pixel in the frame; returns 0 when it is dropped.
  function automatic bit place_pixel(output logic [IDX_W-1:0] idx, output bit done_now);
    int unsigned cols;
    int unsigned rows;
    int unsigned dest_row;
    int unsigned flat;
    cols = clamp_dim(columns_q, MAX_COLUMNS);
    rows = clamp_dim(rows_q, MAX_ROWS);
    idx = '0;
    done_now = 1'b0;
    if (image_full) return 1'b0;
    if (column >= cols || row >= rows) begin
      image_full = 1'b1;
      return 1'b0;
    end
    dest_row = flip_q ? rows - 1 - row : row;
    flat = dest_row * cols + column;
    idx = flat[IDX_W-1:0];
    placed_total = placed_total + 1'b1;
    column++;
    if (column >= cols) begin
      column = 0;
      row++;
      if (row >= rows) image_full = 1'b1;
    end
    done_now = image_full;
    return 1'b1;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic start);
    pixel_pair_t      pair;
    pixel_pair_t      batch[$];
    logic [PIX_W-1:0] rgba;
    logic [IDX_W-1:0] idx;
    logic [1:0]       last_pos;
    bit               done_now;
    bit               half_pair;
    int               k;
    if (start) clear_counters();
    if (header_next) begin
      if (b < HDR_REPEAT_MIN) begin
        in_repeat   = 1'b0;
        pixels_left = b + 8'd1;
      end else begin
        in_repeat   = 1'b1;
        pixels_left = b - REPEAT_BIAS;
      end
      header_next = 1'b0;
      byte_pos    = '0;
      gather      = '0;
      return;
    end
    gather = gather | (32'(b) << (8 * byte_pos));
    last_pos = four_byte_q ? 2'd3 : 2'd2;
    if (byte_pos < last_pos) begin
      byte_pos = byte_pos + 2'd1;
      return;
    end
    // Source order is blue, green, red, alpha; the word goes out as RGBA.
    rgba = {gather[23:16], gather[15:8], gather[7:0], four_byte_q ? gather[31:24] : 8'h00};
    byte_pos = '0;
    gather   = '0;

    if (!in_repeat) begin
      if (pixels_left > 0) pixels_left = pixels_left - 8'd1;
      if (pixels_left == 0) header_next = 1'b1;
      if (place_pixel(idx, done_now)) begin
        pair = '0;
        pair.first_pixel = rgba;
        pair.first_index = idx;
        pair.run_last    = 1'b1;
        pair.image_done  = done_now;
        pairs_due.push_back(pair);
      end
      return;
    end

    half_pair = 1'b0;
    pair = '0;
    for (k = 0; k < int'(pixels_left); k++) begin
      if (!place_pixel(idx, done_now)) break;
      if (!half_pair) begin
        pair = '0;
        pair.first_pixel = rgba;
        pair.first_index = idx;
        half_pair = 1'b1;
      end else begin
        pair.second_pixel = rgba;
        pair.second_index = idx;
        pair.second_valid = 1'b1;
        half_pair = 1'b0;
      end
      if (done_now) pair.image_done = 1'b1;
      if (!half_pair || done_now) begin
        batch.push_back(pair);
        half_pair = 1'b0;
      end
      if (done_now) break;
    end
    if (half_pair) batch.push_back(pair);
    pixels_left = '0;
    header_next = 1'b1;
    if (batch.size() > 0) begin
      pair = batch.pop_back();
      pair.run_last = 1'b1;
      batch.push_back(pair);
    end
    foreach (batch[i]) pairs_due.push_back(batch[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_pair_t want;
    if (!rst_ni) begin
      columns_q   = DIM_W'(1);
      rows_q      = DIM_W'(1);
      four_byte_q = 1'b0;
      flip_q      = 1'b0;
      clear_counters();
      pairs_due.delete();
      mismatches    = 0;
      words_checked = 0;
      pending_o  <= 0;
      mismatch_o <= 0;
      checked_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_COLUMNS:   columns_q   = cfg_data_i;
          CFG_ROWS:      rows_q      = cfg_data_i;
          CFG_FOUR_BYTE: four_byte_q = cfg_data_i[0];
          CFG_FLIP:      flip_q      = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) decode_byte(data_byte_i, image_start_i);
      if (out_valid_i && out_ready_i) begin
        words_checked++;
        if (pairs_due.size() == 0) begin
          $error("result word arrived with no expectation waiting");
          mismatches++;
        end else begin
          want = pairs_due.pop_front();
          check_field("first_pixel", want.first_pixel, first_pixel_i);
          check_field("first_index", 32'(want.first_index), 32'(first_index_i));
          check_field("second_pixel", want.second_pixel, second_pixel_i);
          check_field("second_index", 32'(want.second_index), 32'(second_index_i));
          check_field("second_valid", 32'(want.second_valid), 32'(second_valid_i));
          check_field("run_last", 32'(want.run_last), 32'(run_last_i));
          check_field("image_done", 32'(want.image_done), 32'(image_done_i));
        end
      end
      pending_o  <= pairs_due.size();
      mismatch_o <= mismatches;
      checked_o  <= words_checked;
    end
  end

endmodule

/* verif/testbench.sv */
module testbench import tgarle_pkg::*; ();

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int STREAM_BYTES = 400;
  // A full repeat packet holds the block while its pixels are placed one by one.
  localparam int SETTLE_CYCLES = 400;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [7:0]           data_byte_i;
  logic                 image_start_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [PIX_W-1:0]     first_pixel_o;
  logic [IDX_W-1:0]     first_index_o;
  logic [PIX_W-1:0]     second_pixel_o;
  logic [IDX_W-1:0]     second_index_o;
  logic                 second_valid_o;
  logic                 run_last_o;
  logic                 image_done_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DIM_W-1:0]     cfg_data_i;

  int pending_words;
  int mismatch_total;
  int words_checked;
  int cycle_count = 0;
  int bytes_sent  = 0;
  int settings    = 0;
  bit idle_on     = 1'b1;
  bit four_bytes  = 1'b0;

  tga_rle_pixel_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .image_start_i  (image_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .first_pixel_o  (first_pixel_o),
    .first_index_o  (first_index_o),
    .second_pixel_o (second_pixel_o),
    .second_index_o (second_index_o),
    .second_valid_o (second_valid_o),
    .run_last_o     (run_last_o),
    .image_done_o   (image_done_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  tga_rle_pixel_check pixel_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .image_start_i  (image_start_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .first_pixel_i  (first_pixel_o),
    .first_index_i  (first_index_o),
    .second_pixel_i (second_pixel_o),
    .second_index_i (second_index_o),
    .second_valid_i (second_valid_o),
    .run_last_i     (run_last_o),
    .image_done_i   (image_done_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pending_o      (pending_words),
    .mismatch_o     (mismatch_total),
    .checked_o      (words_checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= !(idle_on && $urandom_range(99) < 11);
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tga_rle_pixel_decoder regression: fail");
      $finish;
    end
  end

  // Valid stays high from one word to the next unless an idle gap is drawn.
  task automatic push_byte(input logic [7:0] b, input logic start);
    if (idle_on && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    image_start_i <= start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows,
                            input bit f4, input bit flip);
    write_reg(CFG_COLUMNS, cols);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_FOUR_BYTE, DIM_W'(f4));
    write_reg(CFG_FLIP, DIM_W'(flip));
    cfg_valid_i <= 1'b0;
    four_bytes = f4;
    settings++;
  endtask

  // Holds the sender until every predicted word has come back, then lets
  // the block finish any pixels that produce nothing.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_packet(input bit rep, input int count, input logic start);
    int n;
    push_byte(rep ? 8'(127 + count) : 8'(count - 1), start);
    n = (rep ? 1 : count) * (four_bytes ? 4 : 3);
    repeat (n) push_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
    int unsigned      area;
    int               target;
    int               placed;
    int               count;
    int               images;
    bit               rep;
    bit               fresh;
    bit               first;

    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    data_byte_i   <= '0;
    image_start_i <= 1'b0;
    out_ready_i   <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_COLUMNS;
    cfg_data_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry is one pixel: the first pixel ends the image and the
    // repeat packet after it is dropped.
    push_byte(8'h00, 1'b1);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'hBB, 1'b0);
    push_byte(8'hCC, 1'b0);
    drain();

    // Longest repeat packet, clipped by a small flipped image.
    set_config(DIM_W'(3), DIM_W'(2), 1'b1, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    drain();

    // Largest frame, flipped: the first pixels land in the last row of the frame.
    set_config(DIM_W'(MAX_COLUMNS), DIM_W'(MAX_ROWS), 1'b0, 1'b1);
    push_byte(8'h01, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    drain();

    // Pixel width drops from four bytes to three once three bytes have been
    // gathered: the next byte lands in the alpha slot and completes the pixel.
    set_config(DIM_W'(2), DIM_W'(1), 1'b1, 1'b0);
    push_byte(8'h7F, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b0);
    drain();
    set_config(DIM_W'(2), DIM_W'(1), 1'b0, 1'b0);
    push_byte(8'h04, 1'b0);

    while (bytes_sent < STREAM_BYTES) begin
      drain();
      // Every third setting runs with both sides streaming flat out.
      idle_on = (settings % 3 != 2);
      case ($urandom_range(15))
        0: begin cols = DIM_W'(MAX_COLUMNS); rows = DIM_W'($urandom_range(1, 3)); end
        1: begin cols = DIM_W'($urandom_range(1, 3)); rows = DIM_W'(MAX_ROWS); end
        2: begin cols = '0; rows = '0; end
        3: begin cols = DIM_W'($urandom_range(4097, 8191)); rows = DIM_W'($urandom_range(0, 2)); end
        4: begin cols = DIM_W'($urandom); rows = DIM_W'($urandom); end
        default: begin cols = DIM_W'($urandom_range(1, 12)); rows = DIM_W'($urandom_range(1, 6)); end
      endcase
      set_config(cols, rows, 1'($urandom_range(1)), 1'($urandom_range(1)));
      area = (cols == 0 ? 1 : (cols > MAX_COLUMNS ? MAX_COLUMNS : int'(cols))) *
             (rows == 0 ? 1 : (rows > MAX_ROWS ? MAX_ROWS : int'(rows)));
      // Now and then the old image carries on under the new geometry.
      fresh = ($urandom_range(3) != 0);
      images = $urandom_range(1, 2);
      for (int img = 0; img < images; img++) begin
        target = (area > 64) ? $urandom_range(20, 60) : int'(area) + $urandom_range(0, 4);
        placed = 0;
        first = fresh || img > 0;
        while (placed < target) begin
          if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom), $urandom_range(9) == 0);
          end
          rep = $urandom_range(1);
          if (rep)
            count = ($urandom_range(19) == 0) ? $urandom_range(9, 128) : $urandom_range(1, 8);
          else
            count = ($urandom_range(19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
          send_packet(rep, count, first);
          first = 1'b0;
          placed += count;
        end
      end
    end

    idle_on = 1'b1;
    drain();
    $display("Streamed %0d bytes under %0d register settings; %0d result words checked.",
             bytes_sent, settings, words_checked);
    if (mismatch_total == 0) begin
      $display("tga_rle_pixel_decoder regression: pass");
    end else begin
      $display("tga_rle_pixel_decoder regression: fail");
    end
    $finish;
  end

endmodule
